// File: src/mte_pkg.sv
package mte_pkg;

	localparam int unsigned CODE_W = 7;
	localparam int unsigned SYM_W  = 3;

	localparam logic [SYM_W-1:0] SYM_DOT  = 3'd0;
	localparam logic [SYM_W-1:0] SYM_DASH = 3'd1;
	localparam logic [SYM_W-1:0] SYM_LGAP = 3'd2;
	localparam logic [SYM_W-1:0] SYM_WGAP = 3'd3;
	localparam logic [SYM_W-1:0] SYM_ERR  = 3'd4;

	// lookup result: 7-bit code, all ones marks an unmapped byte
	localparam logic [7:0] CODE_ERR  = 8'hFF;
	localparam logic [7:0] CODE_WGAP = 8'h00;

	localparam logic [7:0] BYTE_C2    = 8'hC2;
	localparam logic [7:0] BYTE_C3    = 8'hC3;
	localparam logic [7:0] BYTE_SHARP = 8'd159;
	localparam logic [7:0] BYTE_PCT   = 8'h25;

	localparam logic [CODE_W-1:0] CODE_S     = 7'h08;
	localparam logic [CODE_W-1:0] CODE_ZERO  = 7'h3F;
	localparam logic [CODE_W-1:0] CODE_SLASH = 7'h29;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_C2,
		PFX_C3
	} pfx_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} mte_cmd_t;

	typedef struct packed {
		logic prefix_hold;
		logic step_last;
		logic out_free;
	} mte_status_t;

	localparam logic [CODE_W-1:0] LETTER_ROM [26] = '{
		7'h06, 7'h11, 7'h15, 7'h09, 7'h02, 7'h14, 7'h0B, 7'h10, 7'h04, 7'h1E, 7'h0D, 7'h12,
		7'h07, 7'h05, 7'h0F, 7'h16, 7'h1B, 7'h0A, 7'h08, 7'h03, 7'h0C, 7'h18, 7'h0E, 7'h19,
		7'h1D, 7'h1C
	};

	localparam logic [CODE_W-1:0] DIGIT_ROM [20] = '{
		7'h22, 7'h5E, 7'h32, 7'h6D, 7'h19, 7'h2A, 7'h73, 7'h61, 7'h6A, 7'h29,
		7'h3F, 7'h3E, 7'h3C, 7'h38, 7'h30, 7'h20, 7'h21, 7'h23, 7'h27, 7'h2F
	};

	// code for a folded byte with no prefix
	function automatic logic [7:0] plain_code(input logic [7:0] c);
		logic [7:0] r;
		logic [7:0] off;
		off = 8'd0;
		r = CODE_ERR;
		case (c) inside
			[8'd97:8'd122]: begin
				off = c - 8'd97;
				r = {1'b0, LETTER_ROM[off[4:0]]};
			end
			[8'd38:8'd57]: begin
				off = c - 8'd38;
				r = {1'b0, DIGIT_ROM[off[4:0]]};
			end
			8'd32, 8'd10: r = CODE_WGAP;
			8'd33, 8'd34, 8'd64: r = 8'h56;
			8'd58: r = 8'h78;
			8'd61: r = 8'h31;
			8'd63: r = 8'h4C;
			8'd62: r = 8'h28;
			8'd36: r = 8'h0D;
			default: r = CODE_ERR;
		endcase
		return r;
	endfunction

	// code for the byte after a 0xc2 or 0xc3 prefix
	function automatic logic [7:0] prefixed_code(input pfx_t p, input logic [7:0] c);
		logic [7:0] r;
		r = CODE_ERR;
		if (p == PFX_C2) begin
			case (c)
				8'd161: r = 8'h56;
				8'd191: r = 8'h4C;
				default: r = CODE_ERR;
			endcase
		end else begin
			case (c) inside
				[8'd160:8'd165]: r = 8'h06;
				8'd166: r = 8'h1A;
				8'd167: r = 8'h25;
				[8'd168:8'd171]: r = 8'h02;
				[8'd172:8'd175]: r = 8'h04;
				8'd176: r = 8'h2C;
				8'd177: r = 8'h3B;
				[8'd178:8'd182]: r = 8'h0F;
				8'd184: r = 8'h17;
				[8'd185:8'd188]: r = 8'h0C;
				8'd189, 8'd191: r = 8'h1D;
				8'd190: r = 8'h26;
				default: r = CODE_ERR;
			endcase
		end
		return r;
	endfunction

endpackage

// File: src/mte_ctrl.sv
module mte_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_stall,
	input  mte_pkg::mte_status_t status,
	output mte_pkg::mte_cmd_t    cmd
);
	import mte_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		text_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				text_stall = 1'b0;
				if (text_valid) begin
					cmd.load = 1'b1;
					// a prefix byte only updates the pending prefix
					if (!status.prefix_hold) state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.step_last) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: src/mte_datapath.sv
module mte_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 text_byte,
	input  mte_pkg::mte_cmd_t          cmd,
	output mte_pkg::mte_status_t       status,
	output logic                       sym_valid,
	input  logic                       sym_stall,
	output logic [mte_pkg::SYM_W-1:0]  symbol,
	output logic                       last
);
	import mte_pkg::*;

	pfx_t              pending_q;
	logic [CODE_W-1:0] shift_q, q1_q, q2_q;
	logic [1:0]        n_q;
	logic              err_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  symbol_q;
	logic              last_q;

	// decode of the incoming byte
	logic [7:0]        folded;
	logic [7:0]        code0;
	logic [CODE_W-1:0] code1, code2;
	logic [1:0]        count;
	logic              is_prefix;
	pfx_t              new_pfx;

	always_comb begin
		folded = text_byte;
		if (text_byte >= 8'd65 && text_byte <= 8'd90) folded = text_byte + 8'd32;
		code0 = CODE_ERR;
		code1 = CODE_S;
		code2 = CODE_ZERO;
		count = 2'd1;
		is_prefix = 1'b0;
		new_pfx = PFX_NONE;
		if (pending_q != PFX_NONE) begin
			if (pending_q == PFX_C3 && text_byte == BYTE_SHARP) begin
				code0 = {1'b0, CODE_S};
				code1 = CODE_S;
				count = 2'd2;
			end else begin
				code0 = prefixed_code(pending_q, text_byte);
			end
		end else if (text_byte == BYTE_C2 || text_byte == BYTE_C3) begin
			is_prefix = 1'b1;
			new_pfx = (text_byte == BYTE_C2) ? PFX_C2 : PFX_C3;
		end else if (folded == BYTE_PCT) begin
			code0 = {1'b0, CODE_ZERO};
			code1 = CODE_SLASH;
			code2 = CODE_ZERO;
			count = 2'd3;
		end else begin
			code0 = plain_code(folded);
		end
	end

	logic             code_end;
	logic [SYM_W-1:0] sym_d;

	assign code_end = (shift_q <= CODE_W'(1));

	always_comb begin
		if (err_q) sym_d = SYM_ERR;
		else if (shift_q == '0) sym_d = SYM_WGAP;
		else if (shift_q == CODE_W'(1)) sym_d = SYM_LGAP;
		else if (shift_q[0]) sym_d = SYM_DASH;
		else sym_d = SYM_DOT;
	end

	assign status.prefix_hold = is_prefix;
	assign status.step_last   = err_q || (code_end && n_q == 2'd1);
	assign status.out_free    = !out_valid_q || !sym_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= PFX_NONE;
			out_valid_q <= 1'b0;
			n_q         <= 2'd0;
			err_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				pending_q <= new_pfx;
				if (!is_prefix) begin
					n_q   <= count;
					err_q <= (code0 == CODE_ERR);
				end
			end else if (cmd.step && !err_q && code_end) begin
				n_q <= n_q - 2'd1;
			end
			if (cmd.step) out_valid_q <= 1'b1;
			else if (!sym_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= code0[CODE_W-1:0];
			q1_q    <= code1;
			q2_q    <= code2;
		end else if (cmd.step && !err_q) begin
			if (code_end) begin
				shift_q <= q1_q;
				q1_q    <= q2_q;
			end else begin
				shift_q <= shift_q >> 1;
			end
		end
		if (cmd.step) begin
			symbol_q <= sym_d;
			last_q   <= status.step_last;
		end
	end

	assign sym_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;

	a_no_load_and_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step in one cycle");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> sym_valid)
		else $error("step did not fill the output register");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && err_q) |=> (symbol == SYM_ERR && last))
		else $error("error symbol not sent alone");

	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!out_valid_q || !sym_stall))
		else $error("output overwritten while stalled");

endmodule

// File: src/morse_text_encoder.sv
// channel | direction | handshake               | payload
// text    | in        | text_valid / text_stall | text_byte[7:0]
// sym     | out       | sym_valid / sym_stall   | symbol[2:0], last
//
// the controller takes a byte while idle, then steps out each symbol it produces
// (1 to 18), shifting the code one element a cycle while the output is free;
// no new byte is taken until the last symbol of the byte has been stepped.
// a 0xc2 or 0xc3 prefix byte produces nothing; it only sets the pending prefix.
// arst_n clears the sequencer, the pending prefix and the output valid.
// a stall on the output holds the symbol register and pauses the sequencer.
module morse_text_encoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      text_valid,
	output logic                      text_stall,
	input  logic [7:0]                text_byte,
	output logic                      sym_valid,
	input  logic                      sym_stall,
	output logic [mte_pkg::SYM_W-1:0] symbol,
	output logic                      last
);
	import mte_pkg::*;

	mte_cmd_t    cmd;
	mte_status_t status;

	mte_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.status     (status),
		.cmd        (cmd)
	);

	mte_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (text_byte),
		.cmd       (cmd),
		.status    (status),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.symbol    (symbol),
		.last      (last)
	);

endmodule
